[src/tlf_pkg.sv]
`default_nettype none

package tlf_pkg;

   localparam int MAX_COLUMN = 32;
   localparam int ADDR_W     = $clog2(MAX_COLUMN);
   localparam int FILL_W     = $clog2(MAX_COLUMN + 1);
   localparam int CHAR_W     = 8;
   localparam int CFG_W      = 6;

   localparam logic [CFG_W-1:0]  FOLD_WIDTH_RESET = CFG_W'(30);
   localparam logic [CHAR_W-1:0] CHAR_NL  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_SP  = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;

   typedef struct packed {
      logic in_ready;
      logic store_now;
      logic take;
      logic emit_data;
      logic emit_break;
   } cmd_type;

   typedef struct packed {
      logic in_valid;
      logic in_is_nl;
      logic in_fold;
      logic more;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[src/tlf_if.sv]
`default_nettype none

interface tlf_req_if import tlf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface tlf_rsp_if import tlf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last_of_run;

   modport source (output valid, output char_out, output last_of_run, input ready);
   modport sink   (input valid, input char_out, input last_of_run, output ready);
endinterface

`default_nettype wire

[src/tlf_ctrl.sv]
`default_nettype none

module tlf_ctrl import tlf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT,
      S_BREAK
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.in_valid) begin
               if (!status.in_is_nl && !status.in_fold) begin
                  cmd.store_now = 1'b1;
               end else begin
                  cmd.take = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // read data lands in the registered output of the line store
            state_in = status.more ? S_EMIT : S_BREAK;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_data = 1'b1;
               state_in      = S_READ;
            end
         end
         S_BREAK: begin
            if (status.out_free) begin
               cmd.emit_break = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/tlf_dp.sv]
`default_nettype none

module tlf_dp import tlf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   tlf_req_if.sink                req_ch,
   tlf_rsp_if.source              rsp_ch,
   input  wire logic              csr_wr_en,
   input  wire logic [CFG_W-1:0]  csr_wr_data,
   input  wire cmd_type           cmd,
   output status_type             status
);

   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [FILL_W-1:0] off);
      logic [FILL_W:0] sum;
      sum = {{(FILL_W+1-ADDR_W){1'b0}}, base} + {1'b0, off};
      if (sum >= (FILL_W+1)'(MAX_COLUMN)) begin
         sum = sum - (FILL_W+1)'(MAX_COLUMN);
      end
      return sum[ADDR_W-1:0];
   endfunction

   logic [CHAR_W-1:0] mem [MAX_COLUMN];
   logic [CHAR_W-1:0] rdata_ff;

   logic [CFG_W-1:0]  width_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] bp_ff;
   logic              pwb_ff;
   logic [ADDR_W-1:0] base_ff;

   logic [CHAR_W-1:0] char_ff;
   logic              nl_ff;
   logic              bpfold_ff;
   logic [FILL_W-1:0] cnt_ff;
   logic [FILL_W-1:0] idx_ff;

   logic              out_valid_ff;
   logic [CHAR_W-1:0] out_char_ff;
   logic              out_last_ff;

   logic [FILL_W-1:0] eff_w;
   logic              in_is_nl;
   logic              bp_ok;
   logic [FILL_W-1:0] cnt_in;
   logic [ADDR_W-1:0] rd_addr;

   logic              do_store;
   logic [FILL_W-1:0] f_sel;
   logic [FILL_W-1:0] f_next;
   logic [ADDR_W-1:0] base_sel;
   logic [FILL_W-1:0] bp_base;
   logic [CHAR_W-1:0] st_char;
   logic              st_blank;
   logic [ADDR_W-1:0] wr_addr;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = FILL_W'(1);
      end else if (width_ff > CFG_W'(MAX_COLUMN)) begin
         eff_w = FILL_W'(MAX_COLUMN);
      end else begin
         eff_w = FILL_W'(width_ff);
      end
   end

   assign in_is_nl = (req_ch.char_in == CHAR_NL);
   assign bp_ok    = (bp_ff != '0) && (bp_ff <= fill_ff);
   assign cnt_in   = (!in_is_nl && bp_ok) ? bp_ff - FILL_W'(1) : fill_ff;
   assign rd_addr  = wrap_add(base_ff, idx_ff);

   assign status.in_valid = req_ch.valid;
   assign status.in_is_nl = in_is_nl;
   assign status.in_fold  = (fill_ff >= eff_w);
   assign status.more     = (idx_ff < cnt_ff);
   assign status.out_free = !out_valid_ff || rsp_ch.ready;

   assign req_ch.ready       = cmd.in_ready;
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.char_out    = out_char_ff;
   assign rsp_ch.last_of_run = out_last_ff;

   // store step: either a plain buffered byte or the byte that caused a fold
   always_comb begin
      do_store = cmd.store_now || (cmd.emit_break && !nl_ff);
      if (cmd.emit_break) begin
         f_sel    = bpfold_ff ? fill_ff - bp_ff : '0;
         base_sel = bpfold_ff ? wrap_add(base_ff, bp_ff) : base_ff;
         bp_base  = '0;
         st_char  = char_ff;
      end else begin
         f_sel    = fill_ff;
         base_sel = base_ff;
         bp_base  = bp_ff;
         st_char  = req_ch.char_in;
      end
      f_next   = f_sel + FILL_W'(1);
      st_blank = (st_char == CHAR_SP) || (st_char == CHAR_TAB);
      wr_addr  = wrap_add(base_sel, f_sel);
   end

   always_ff @(posedge clock) begin
      if (do_store) begin
         mem[wr_addr] <= st_char;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= FOLD_WIDTH_RESET;
         fill_ff      <= '0;
         bp_ff        <= '0;
         pwb_ff       <= 1'b0;
         base_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         if (do_store) begin
            fill_ff <= f_next;
            base_ff <= base_sel;
            bp_ff   <= (st_blank && !pwb_ff) ? f_next : bp_base;
            pwb_ff  <= st_blank;
         end else if (cmd.emit_break) begin
            fill_ff <= '0;
            bp_ff   <= '0;
            pwb_ff  <= 1'b0;
         end
         if (cmd.emit_data || cmd.emit_break) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         char_ff   <= req_ch.char_in;
         nl_ff     <= in_is_nl;
         bpfold_ff <= bp_ok;
         cnt_ff    <= cnt_in;
         idx_ff    <= '0;
      end else if (cmd.emit_data) begin
         idx_ff <= idx_ff + FILL_W'(1);
      end
      if (cmd.emit_data) begin
         out_char_ff <= rdata_ff;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_break) begin
         out_char_ff <= CHAR_NL;
         out_last_ff <= 1'b1;
      end
   end

`ifndef ASSERT_OFF
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_COLUMN))
      else $error("line fill above capacity");

   a_bp_in_line: assert property (@(posedge clock) disable iff (reset)
      bp_ff <= fill_ff)
      else $error("break point beyond buffered line");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_data || cmd.emit_break) |-> (!out_valid_ff || rsp_ch.ready))
      else $error("output register overwritten while stalled");

   a_plain_store: assert property (@(posedge clock) disable iff (reset)
      cmd.store_now |-> (req_ch.valid && !in_is_nl && (fill_ff < eff_w)))
      else $error("direct store on a newline or fold request");
`endif

endmodule

`default_nettype wire

[src/text_line_folder.sv]
// text_line_folder: folds a byte stream into lines of at most fold_width columns.
// req_ch carries one character per request (valid/ready); rsp_ch returns the
// emitted bytes, with last_of_run set on the final byte caused by a request.
// csr_wr_en/csr_wr_data write fold_width; write it only while the block is idle.
// Ordinary bytes are only buffered: such a request is taken with no response,
// and the next one can follow in the following cycle.
// A newline, or a byte arriving when the line already holds fold_width bytes,
// emits k buffered bytes and a newline: each byte is read from the line store
// into its registered read data, then loaded into the output register; the
// next request is taken only after the newline has been loaded.
// A fold breaks at the start of the last blank run, or hard-breaks the line.
// Each emitted byte takes one read of the line store's separate read port.
// Reset empties the line, clears the break marker and sets fold_width to 30;
// the line store itself is not cleared; unwritten entries are never emitted.
// When the receiver stalls, the output register holds its byte and the
// emission sequence waits; no byte is lost. A final byte waiting in the output
// register does not block the next request.
`default_nettype none

module text_line_folder import tlf_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   tlf_req_if.sink               req_ch,
   tlf_rsp_if.source             rsp_ch,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   tlf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tlf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire
